// File: hw/rtl/shifting_array_list_defines.svh
// Assertion macros for the shifting array list checker.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef SHIFTING_ARRAY_LIST_DEFINES_SVH
`define SHIFTING_ARRAY_LIST_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define SAL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define SAL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/sal_pkg.sv
// Shared types and constants of the shifting array list.
// No dependencies; used by the interfaces, the cell, the top level and the checker.
package sal_pkg;

    // Payload field widths
    localparam int MODE_W = 3;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int FCNT_W = 6;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 6;

    // List depth: default and upper bound
    localparam int DEPTH_DEF = 32;
    localparam int DEPTH_MAX = 64;

    // Width of index and count fields broadcast to the cells
    localparam int IX_W = $clog2(DEPTH_MAX + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 3'd0,
        MODE_POP    = 3'd1,
        MODE_DELETE = 3'd2,
        MODE_INSERT = 3'd3,
        MODE_FILL   = 3'd4,
        MODE_DUMP   = 3'd5
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    // Action that every cell evaluates against its own index
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_APPEND = 3'd1,
        CELL_DELETE = 3'd2,
        CELL_INSERT = 3'd3,
        CELL_FILL   = 3'd4,
        CELL_ROTATE = 3'd5
    } t_cell_op;

    typedef struct packed {
        t_cell_op         op;
        logic [IX_W-1:0]  pos;
        logic [IX_W-1:0]  cnt;
        logic [IX_W-1:0]  fcnt;
        logic [VAL_W-1:0] value;
    } t_cell_cmd;

endpackage

// File: hw/rtl/sal_in_if.sv
// Input channel of the shifting array list: valid/ready plus one list operation.
// Depends on sal_pkg for field widths.
interface sal_in_if;
    logic                               valid;
    logic                               ready;
    logic        [sal_pkg::MODE_W-1:0]  mode;
    logic        [sal_pkg::POS_W-1:0]   position;
    logic signed [sal_pkg::VAL_W-1:0]   value;
    logic        [sal_pkg::FCNT_W-1:0]  fill_count;

    modport source (output valid, mode, position, value, fill_count, input ready);
    modport sink   (input valid, mode, position, value, fill_count, output ready);
endinterface

// File: hw/rtl/sal_out_if.sv
// Result channel of the shifting array list: valid/ready plus one result item.
// Depends on sal_pkg for field widths.
interface sal_out_if;
    logic                               valid;
    logic                               ready;
    logic        [sal_pkg::STAT_W-1:0]  status;
    logic        [sal_pkg::CNT_W-1:0]   count;
    logic signed [sal_pkg::VAL_W-1:0]   element;
    logic                               has_element;
    logic                               last;

    modport source (output valid, status, count, element, has_element, last, input ready);
    modport sink   (input valid, status, count, element, has_element, last, output ready);
endinterface

// File: hw/rtl/sal_cell.sv
// One storage cell of the shifting array list chain.
// Depends on sal_pkg; decodes the broadcast command against its own index.
module sal_cell #(
    parameter int IDX = 0
) (
    input  logic                      i_clk,
    input  sal_pkg::t_cell_cmd        i_cmd,
    input  logic [sal_pkg::VAL_W-1:0] i_left,
    input  logic [sal_pkg::VAL_W-1:0] i_right,
    input  logic [sal_pkg::VAL_W-1:0] i_wrap,
    output logic [sal_pkg::VAL_W-1:0] o_data
);
    import sal_pkg::*;

    localparam logic [IX_W-1:0]  ME   = IX_W'(IDX);
    localparam logic [IX_W-1:0]  ME1  = IX_W'(IDX + 1);
    localparam logic [VAL_W-1:0] FOFF = VAL_W'(IDX) << 16;

    logic [VAL_W-1:0] r_data;
    logic [VAL_W-1:0] n_data;

    // Pick the next value of this slot
    always_comb begin
        n_data = r_data;
        case (i_cmd.op)
            CELL_APPEND: begin
                if (ME == i_cmd.cnt) n_data = i_cmd.value;
            end
            CELL_DELETE: begin
                if (ME >= i_cmd.pos && ME1 < i_cmd.cnt) n_data = i_right;
            end
            CELL_INSERT: begin
                if (ME == i_cmd.pos) begin
                    n_data = i_cmd.value;
                end else if (ME > i_cmd.pos && ME <= i_cmd.cnt) begin
                    n_data = i_left;
                end
            end
            CELL_FILL: begin
                if (ME < i_cmd.fcnt) n_data = i_cmd.value + FOFF;
            end
            CELL_ROTATE: begin
                // Move toward the head; the tail slot takes the old head
                if (ME1 < i_cmd.cnt) begin
                    n_data = i_right;
                end else if (ME1 == i_cmd.cnt) begin
                    n_data = i_wrap;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: hw/rtl/shifting_array_list.sv
// Shifting array list: an ordered list of up to DEPTH Q16.16 values in a chain of cells
// that all shift at once. Append, pop, delete, insert and fill each give one result; a dump
// of n elements gives n results, one per cycle while the output register is not stalled,
// paced by the single output register fed from the head cell (the list rotates once through
// it), and holds off the next item until its last result is loaded (an empty list gives
// one bare result). A new item is taken when no dump is running and the output register
// is free or being emptied. Storage needs no clearing after reset; only slots below the
// count are read. Depends on sal_pkg, sal_in_if, sal_out_if and sal_cell.
module shifting_array_list #(
    parameter int DEPTH = sal_pkg::DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sal_in_if.sink    i_in,
    sal_out_if.source o_out
);
    import sal_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IX_W-1:0] DEPTH_K = IX_W'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_valid, n_valid;
    t_status            r_status, n_status;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [VAL_W-1:0]   r_elem, n_elem;
    logic               r_has, n_has;
    logic               r_last, n_last;

    logic               w_out_free;
    logic               w_accept;
    logic [IX_W-1:0]    w_cntk;
    logic [IX_W-1:0]    w_posk;
    logic [IX_W-1:0]    w_fcntk;
    logic               w_dump_last;
    t_cell_cmd          w_cmd;
    logic [VAL_W-1:0]   w_data [DEPTH];

    assign w_out_free  = !r_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && w_out_free;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_cntk      = IX_W'(r_cnt);
    assign w_posk      = IX_W'(i_in.position);
    assign w_fcntk     = IX_W'(i_in.fill_count);
    assign w_dump_last = ((CW + 1)'(r_idx) + (CW + 1)'(1)) == (CW + 1)'(r_cnt);

    // Decode the item, drive the cells and load the output register
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_valid     = r_valid && !o_out.ready;
        n_status    = r_status;
        n_count     = r_count;
        n_elem      = r_elem;
        n_has       = r_has;
        n_last      = r_last;
        w_cmd.op    = CELL_HOLD;
        w_cmd.pos   = w_posk;
        w_cmd.cnt   = w_cntk;
        w_cmd.fcnt  = w_fcntk;
        w_cmd.value = i_in.value;

        if (w_accept) begin
            n_status = ST_DONE;
            case (i_in.mode)
                MODE_APPEND: begin
                    if (w_cntk == DEPTH_K) begin
                        n_status = ST_FULL;
                    end else begin
                        w_cmd.op = CELL_APPEND;
                        n_cnt    = r_cnt + CW'(1);
                    end
                end
                MODE_POP: begin
                    if (r_cnt == '0) begin
                        n_status = ST_BAD;
                    end else begin
                        n_cnt = r_cnt - CW'(1);
                    end
                end
                MODE_DELETE: begin
                    if (w_posk >= w_cntk) begin
                        n_status = ST_BAD;
                    end else begin
                        w_cmd.op = CELL_DELETE;
                        n_cnt    = r_cnt - CW'(1);
                    end
                end
                MODE_INSERT: begin
                    if (w_posk > w_cntk) begin
                        n_status = ST_BAD;
                    end else if (w_cntk == DEPTH_K) begin
                        n_status = ST_FULL;
                    end else begin
                        w_cmd.op = CELL_INSERT;
                        n_cnt    = r_cnt + CW'(1);
                    end
                end
                MODE_FILL: begin
                    if (w_fcntk > DEPTH_K) begin
                        n_status = ST_FULL;
                    end else begin
                        w_cmd.op = CELL_FILL;
                        n_cnt    = CW'(i_in.fill_count);
                    end
                end
                MODE_DUMP: begin
                    if (r_cnt != '0) begin
                        n_state = S_DUMP;
                        n_idx   = '0;
                    end
                end
                default: ;
            endcase

            // Every item but a non-empty dump answers once, right away
            if (!(i_in.mode == MODE_DUMP && r_cnt != '0)) begin
                n_valid = 1'b1;
                n_count = CNT_W'(n_cnt);
                n_elem  = '0;
                n_has   = 1'b0;
                n_last  = 1'b1;
            end
        end else if (r_state == S_DUMP && w_out_free) begin
            // Emit the head element and rotate the list by one slot
            w_cmd.op = CELL_ROTATE;
            n_valid  = 1'b1;
            n_status = ST_DONE;
            n_count  = CNT_W'(r_cnt);
            n_elem   = w_data[0];
            n_has    = 1'b1;
            n_last   = w_dump_last;
            n_idx    = r_idx + CW'(1);
            if (w_dump_last) n_state = S_IDLE;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_count  <= n_count;
        r_elem   <= n_elem;
        r_has    <= n_has;
        r_last   <= n_last;
    end

    // Chain of storage cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VAL_W-1:0] w_left;
        logic [VAL_W-1:0] w_right;

        if (g == 0) begin : g_head
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        sal_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .i_wrap  (w_data[0]),
            .o_data  (w_data[g])
        );
    end

    assign o_out.valid       = r_valid;
    assign o_out.status      = r_status;
    assign o_out.count       = r_count;
    assign o_out.element     = r_elem;
    assign o_out.has_element = r_has;
    assign o_out.last        = r_last;

endmodule

// File: hw/rtl/sal_checker.sv
// Port-level checks for the shifting array list, bound to the top level.
// Depends on sal_pkg and shifting_array_list_defines.svh.
`include "shifting_array_list_defines.svh"

module sal_checker #(
    parameter int DEPTH = sal_pkg::DEPTH_DEF
) (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [sal_pkg::STAT_W-1:0] i_status,
    input logic [sal_pkg::CNT_W-1:0]  i_count,
    input logic [sal_pkg::VAL_W-1:0]  i_element,
    input logic                       i_has_element,
    input logic                       i_last
);
    import sal_pkg::*;

    localparam logic [CNT_W:0] DEPTH_C = (CNT_W + 1)'(DEPTH);

    // A stalled result holds its payload
    `SAL_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_status) && $stable(i_count) && $stable(i_element) && $stable(i_last),
        "result changed while stalled")

    // No new item enters while a dump is still streaming
    `SAL_ASSERT_NOW(a_dump_blocks_in, i_out_valid && !i_last, !i_in_ready,
        "item accepted in the middle of a dump")

    // A rejected operation answers once with no element
    `SAL_ASSERT_NOW(a_reject_single, i_out_valid && (i_status != ST_DONE),
        i_last && !i_has_element, "rejected item gave more than a bare result")

    // Count never exceeds the depth (checked only for a depth of 63 or less)
    `SAL_ASSERT_NOW(a_count_bound, i_out_valid,
        (DEPTH > 63) || ({1'b0, i_count} <= DEPTH_C), "count above depth")

    // Results without an element carry zero
    `SAL_ASSERT_NOW(a_elem_zero, i_out_valid && !i_has_element, i_element == '0,
        "element field not zero")

endmodule

bind shifting_array_list sal_checker #(
    .DEPTH (DEPTH)
) u_sal_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_status      (o_out.status),
    .i_count       (o_out.count),
    .i_element     (o_out.element),
    .i_has_element (o_out.has_element),
    .i_last        (o_out.last)
);
